[hdl/smh_pkg.sv]
// Shared types and constants for the sliding-window median filter.
// No dependencies; used by sliding_median_histogram_top and its testbench.
package smh_pkg;

  // Register file decode: paddr[3:2] selects the register.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_VALUE     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_VALUE    = 2'd2;

  localparam int unsigned WLEN_W = 7;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd9;

  typedef enum logic [2:0] {
    ST_CLEAR,    // zeroing histogram, one bin per cycle
    ST_IDLE,     // waiting for a sample
    ST_RING_RD,  // oldest bin index arrives from the ring
    ST_DEC,      // retire oldest bin, store new ring entry
    ST_INC_RD,   // read bin of new sample
    ST_INC,      // bump bin of new sample
    ST_SCAN,     // cumulative walk over bins
    ST_OUT       // hand median to output register
  } state_e;

endpackage

[hdl/smh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sliding_median_histogram_top.sv]
// Sliding-window median filter, top level.
// Depends on smh_pkg and smh_ram.
//
// Usage:
// - Input channel in_valid_i/in_ready_o carries sample_i; output channel
//   out_valid_o/out_ready_i carries median_o. A transfer happens on a rising
//   edge with valid and ready both high.
// - Each sample is clamped into [low_value, high_value] and counted in a
//   histogram RAM (BIN_COUNT bins); a ring RAM keeps the window's bin indexes.
//   Once the window is full the oldest sample's bin is decremented first.
// - After the update the histogram is walked from bin 0 upward, one bin per
//   cycle through the histogram RAM read port, until the middle rank is hit.
//   One sample is in flight at a time: the next sample is taken only once the
//   previous one's update is done and, if it yields a median, its walk has
//   ended and that median has been loaded (which waits while the previous
//   median is unaccepted).
// - No median is produced until window_length samples have arrived.
// - Reset (and any write to a valid register) starts a clearing pass that
//   zeroes the histogram one bin at a time; in_ready_o stays low meanwhile.
// - The median sits in an output register; a stalled receiver does not block
//   the next sample, only the loading of the following median.
// - APB: registers at byte addresses 0 (window_length), 4 (low_value),
//   8 (high_value); pready is always high.
module sliding_median_histogram_top #(
  parameter int unsigned BIN_COUNT   = 256,
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // sample channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  // median channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]    median_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [smh_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int unsigned POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SB    = SAMPLE_BITS;
  // range arithmetic width: holds samples and the bin span with sign headroom
  localparam int unsigned CMP_W = (SB + 2 > BIN_W + 2) ? SB + 2 : BIN_W + 2;
  localparam int unsigned MED_W = CMP_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [smh_pkg::WLEN_W-1:0] wlen_q;
  logic signed [SB-1:0]       low_q, high_q;
  logic                       cfg_wr;
  logic                       cfg_hit;
  logic [smh_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[smh_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    cfg_hit = 1'b0;
    prdata  = '0;
    unique case (reg_idx)
      smh_pkg::REG_WINDOW_LENGTH: begin
        cfg_hit = cfg_wr;
        prdata  = 32'(wlen_q);
      end
      smh_pkg::REG_LOW_VALUE: begin
        cfg_hit = cfg_wr;
        prdata  = 32'(low_q);
      end
      smh_pkg::REG_HIGH_VALUE: begin
        cfg_hit = cfg_wr;
        prdata  = 32'(high_q);
      end
      default: begin
        cfg_hit = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= smh_pkg::WLEN_RESET;
      low_q  <= '0;
      high_q <= SB'(255);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        smh_pkg::REG_WINDOW_LENGTH: wlen_q <= pwdata[smh_pkg::WLEN_W-1:0];
        smh_pkg::REG_LOW_VALUE:     low_q  <= pwdata[SB-1:0];
        smh_pkg::REG_HIGH_VALUE:    high_q <= pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Effective range and window, registered every cycle (config is quiet while
  // samples flow, and the clearing pass covers the register delay)
  // ---------------------------------------------------------------------------
  logic signed [CMP_W-1:0] lo_x, hi_x, span_x, hi_lim;
  logic signed [SB-1:0]    eff_lo_d, eff_hi_d;
  logic signed [SB-1:0]    eff_lo_q, eff_hi_q;
  logic [CNT_W-1:0]        eff_w_d, eff_w_q;

  always_comb begin
    if (high_q < low_q) begin
      lo_x = CMP_W'(high_q);
      hi_x = CMP_W'(low_q);
    end else begin
      lo_x = CMP_W'(low_q);
      hi_x = CMP_W'(high_q);
    end
    span_x = hi_x - lo_x;
    hi_lim = lo_x + signed'(CMP_W'(BIN_COUNT - 1));
    eff_lo_d = SB'(lo_x);
    if (span_x > signed'(CMP_W'(BIN_COUNT - 1))) begin
      eff_hi_d = SB'(hi_lim);
    end else begin
      eff_hi_d = SB'(hi_x);
    end
    if (wlen_q == '0) begin
      eff_w_d = CNT_W'(1);
    end else if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
      eff_w_d = CNT_W'(MAX_WINDOW);
    end else begin
      eff_w_d = CNT_W'(wlen_q);
    end
  end

  always_ff @(posedge clk_i) begin
    eff_lo_q <= eff_lo_d;
    eff_hi_q <= eff_hi_d;
    eff_w_q  <= eff_w_d;
  end

  // ranks of the two middle samples (equal for an odd window)
  logic [CNT_W-1:0] rank_a, rank_b;
  assign rank_b = eff_w_q >> 1;
  assign rank_a = eff_w_q[0] ? rank_b : rank_b - CNT_W'(1);

  // clamp incoming sample and turn it into a bin index
  logic [BIN_W-1:0] in_bin;
  logic signed [SB-1:0] s_clamped;
  always_comb begin
    if (sample_i < eff_lo_q) begin
      s_clamped = eff_lo_q;
    end else if (sample_i > eff_hi_q) begin
      s_clamped = eff_hi_q;
    end else begin
      s_clamped = sample_i;
    end
    in_bin = BIN_W'(CMP_W'(s_clamped) - CMP_W'(eff_lo_q));
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic             hist_we;
  logic [BIN_W-1:0] hist_waddr, hist_raddr;
  logic [CNT_W-1:0] hist_wdata, hist_rdata;
  logic             ring_we;
  logic [POS_W-1:0] ring_addr;
  logic [BIN_W-1:0] ring_rdata;
  logic [BIN_W-1:0] bin_q;       // new sample's bin

  smh_ram #(
    .WIDTH(CNT_W),
    .DEPTH(BIN_COUNT)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  smh_ram #(
    .WIDTH(BIN_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_addr),
    .wdata_i(bin_q),
    .raddr_i(ring_addr),
    .rdata_o(ring_rdata)
  );

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  smh_pkg::state_e state_q, state_d;

  logic [BIN_W-1:0] clr_q;
  logic [POS_W-1:0] pos_q;
  logic [CNT_W-1:0] fill_q;
  logic [BIN_W-1:0] old_bin_q;   // retiring sample's bin
  logic             retire_q;    // window was full: drop the oldest
  logic             emit_q;      // window full after this sample
  logic [BIN_W-1:0] scan_addr_q;
  logic [BIN_W-1:0] rd_bin_q;
  logic             rd_vld_q;
  logic [CNT_W:0]   acc_q;
  logic [CNT_W:0]   acc_sum;
  logic             a_found_q;
  logic [BIN_W-1:0] a_q, b_q;
  logic             out_valid_q;
  logic signed [SB-1:0] median_q;

  logic in_xfer, out_load, hit_a, hit_b, pos_wrap;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign acc_sum  = acc_q + (CNT_W + 1)'(hist_rdata);
  assign hit_a    = rd_vld_q && !a_found_q && (acc_sum > (CNT_W + 1)'(rank_a));
  assign hit_b    = rd_vld_q && (acc_sum > (CNT_W + 1)'(rank_b));
  assign out_load = (state_q == smh_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  assign pos_wrap = (CNT_W'(pos_q) + CNT_W'(1)) == eff_w_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smh_pkg::ST_CLEAR:   if (clr_q == BIN_W'(BIN_COUNT - 1)) state_d = smh_pkg::ST_IDLE;
      smh_pkg::ST_IDLE:    if (in_xfer) state_d = smh_pkg::ST_RING_RD;
      smh_pkg::ST_RING_RD: state_d = smh_pkg::ST_DEC;
      smh_pkg::ST_DEC:     state_d = smh_pkg::ST_INC_RD;
      smh_pkg::ST_INC_RD:  state_d = smh_pkg::ST_INC;
      smh_pkg::ST_INC:     state_d = emit_q ? smh_pkg::ST_SCAN : smh_pkg::ST_IDLE;
      smh_pkg::ST_SCAN:    if (hit_b) state_d = smh_pkg::ST_OUT;
      smh_pkg::ST_OUT:     if (out_load) state_d = smh_pkg::ST_IDLE;
      default:             state_d = smh_pkg::ST_CLEAR;
    endcase
    if (cfg_hit) begin
      state_d = smh_pkg::ST_CLEAR;
    end
  end

  // memory controls
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = bin_q;
    hist_wdata = hist_rdata + CNT_W'(1);
    hist_raddr = scan_addr_q;
    ring_we    = 1'b0;
    ring_addr  = pos_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      smh_pkg::ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_q;
        hist_wdata = '0;
      end
      smh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      smh_pkg::ST_RING_RD: begin
        hist_raddr = ring_rdata;
      end
      smh_pkg::ST_DEC: begin
        // a bin already at zero stays there
        hist_we    = retire_q && (hist_rdata != '0);
        hist_waddr = old_bin_q;
        hist_wdata = hist_rdata - CNT_W'(1);
        ring_we    = 1'b1;
      end
      smh_pkg::ST_INC_RD: begin
        hist_raddr = bin_q;
      end
      smh_pkg::ST_INC: begin
        hist_we = 1'b1;
      end
      smh_pkg::ST_SCAN: ;
      smh_pkg::ST_OUT:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smh_pkg::ST_CLEAR;
      clr_q       <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      retire_q    <= 1'b0;
      emit_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      a_found_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_hit) begin
        clr_q  <= '0;
        pos_q  <= '0;
        fill_q <= '0;
      end else if (state_q == smh_pkg::ST_CLEAR) begin
        clr_q <= clr_q + BIN_W'(1);
      end

      if (in_xfer) begin
        retire_q <= (fill_q == eff_w_q);
        emit_q   <= (fill_q == eff_w_q) || ((fill_q + CNT_W'(1)) == eff_w_q);
      end

      if (state_q == smh_pkg::ST_INC && !cfg_hit) begin
        pos_q <= pos_wrap ? '0 : pos_q + POS_W'(1);
        if (!retire_q) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end

      rd_vld_q <= (state_q == smh_pkg::ST_SCAN) && !hit_b;
      if (state_q == smh_pkg::ST_INC) begin
        a_found_q <= 1'b0;
      end else if (hit_a) begin
        a_found_q <= 1'b1;
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // mean of the two middle values, truncated toward zero
  logic signed [MED_W-1:0] med_sum;
  logic signed [SB-1:0]    med_half;
  always_comb begin
    med_sum = MED_W'(eff_lo_q) + MED_W'(eff_lo_q)
            + signed'(MED_W'(a_q)) + signed'(MED_W'(b_q));
    if (med_sum < 0) begin
      med_half = SB'((med_sum + MED_W'(1)) >>> 1);
    end else begin
      med_half = SB'(med_sum >>> 1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      bin_q <= in_bin;
    end
    if (state_q == smh_pkg::ST_RING_RD) begin
      old_bin_q <= ring_rdata;
    end
    if (state_q == smh_pkg::ST_INC) begin
      scan_addr_q <= '0;
      acc_q       <= '0;
    end else if (state_q == smh_pkg::ST_SCAN) begin
      // saturate: the last bin always completes the walk
      if (scan_addr_q != BIN_W'(BIN_COUNT - 1)) begin
        scan_addr_q <= scan_addr_q + BIN_W'(1);
      end
      if (rd_vld_q) begin
        acc_q <= acc_sum;
      end
    end
    rd_bin_q <= scan_addr_q;
    if (hit_a) begin
      a_q <= rd_bin_q;
    end
    if (hit_b) begin
      b_q <= rd_bin_q;
    end
    if (out_load) begin
      median_q <= med_half;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

endmodule

[test/tb_sliding_median_histogram_top.sv]
// Self-checking testbench for sliding_median_histogram_top: directed table plus random phases.
// Depends on smh_pkg and the block's RTL; a local histogram predictor gives each expected median.
module tb_sliding_median_histogram_top;

  localparam int BIN_COUNT   = 256;
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;

  // Settle time; covers the worst-case scan and the clearing pass with margin.
  localparam int SETTLE      = BIN_COUNT + 16;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 124;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int PRINT_CAP   = 40;

  // Address slot past the register list; a write there must change nothing.
  localparam logic [smh_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  // One directed step: a register write, or a sample with an optional known median.
  typedef struct packed {
    row_kind_e                     kind;
    logic [smh_pkg::REG_IDX_W-1:0] idx;
    logic [31:0]                   val;
    logic                          typed;
    logic [SAMPLE_BITS-1:0]        med;
  } plan_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam plan_row_t PLAN [DIRECTED_ROWS] = '{
    // Reset settings: window 9, range 0..255. Both 16-bit extremes clamp to the ends.
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, -32'sd32768, 1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd32767,  1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd255,    1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd100,    1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd100,    1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd100,    1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, -32'sd1,     1'b0, 16'sd0},
    // Window now full: three 0s, three 100s, three 255s.
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd256,    1'b1, 16'sd100},
    // Zero length behaves as a window of one.
    '{ROW_WRITE,  smh_pkg::REG_WINDOW_LENGTH, 32'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd32767,  1'b1, 16'sd255},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, -32'sd32768, 1'b1, 16'sd0},
    // Full 16-bit span is too wide: top end is pulled to low + 255.
    '{ROW_WRITE,  smh_pkg::REG_LOW_VALUE,     -32'sd32768, 1'b0, 16'sd0},
    '{ROW_WRITE,  smh_pkg::REG_HIGH_VALUE,    32'sd32767,  1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd32767,  1'b1, -16'sd32513},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, -32'sd32768, 1'b1, 16'sh8000},
    // Even window over swapped ends; mean of the middle pair truncates toward zero.
    '{ROW_WRITE,  smh_pkg::REG_WINDOW_LENGTH, 32'sd2,      1'b0, 16'sd0},
    '{ROW_WRITE,  smh_pkg::REG_LOW_VALUE,     32'sd100,    1'b0, 16'sd0},
    '{ROW_WRITE,  smh_pkg::REG_HIGH_VALUE,    -32'sd100,   1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, -32'sd7,     1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd4,      1'b1, -16'sd1},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd200,    1'b1, 16'sd52},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, -32'sd300,   1'b1, 16'sd0},
    // Write to the unused slot: window must keep its contents.
    '{ROW_WRITE,  REG_UNUSED,                 32'sd5,      1'b0, 16'sd0},
    '{ROW_SAMPLE, smh_pkg::REG_WINDOW_LENGTH, 32'sd5,      1'b1, -16'sd47}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] median_out;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [smh_pkg::PADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Idle odds per side: 0 = never idle, N = an idle burst starts with odds of about 1 in N.
  int tx_odds = 0;
  int rx_odds = 0;

  int cycles = 0;
  int mismatch_cnt = 0;
  int medians_seen = 0;
  int samples_sent = 0;
  int writes_done = 0;

  // Predictor state: shadow registers, histogram, ring of bin indexes, fill level.
  logic [smh_pkg::WLEN_W-1:0]    cfg_wlen = smh_pkg::WLEN_RESET;
  logic signed [SAMPLE_BITS-1:0] cfg_low = 16'sd0;
  logic signed [SAMPLE_BITS-1:0] cfg_high = 16'sd255;
  int                            bin_cnt [BIN_COUNT];
  int                            ring_bin [MAX_WINDOW];
  int                            ring_pos;
  int                            fill_cnt;

  logic signed [SAMPLE_BITS-1:0] median_q [$];

  sliding_median_histogram_top #(
    .BIN_COUNT  (BIN_COUNT),
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .sample_i   (sample_in),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .median_o   (median_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d medians pending", cycles, median_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report(input string msg);
    if (mismatch_cnt < PRINT_CAP) $display("[cycle %0d] %s", cycles, msg);
    mismatch_cnt++;
  endtask

  function automatic void window_clear();
    foreach (bin_cnt[i]) bin_cnt[i] = 0;
    ring_pos = 0;
    fill_cnt = 0;
  endfunction

  // Effective value range: ends swapped if reversed, span capped at BIN_COUNT - 1.
  function automatic void eff_bounds(output int lo, output int hi);
    int t;
    lo = cfg_low;
    hi = cfg_high;
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    if (hi - lo > BIN_COUNT - 1) hi = lo + BIN_COUNT - 1;
  endfunction

  // Lowest bin whose running count passes the given 0-based rank.
  function automatic int bin_at_rank(input int rank);
    int acc;
    acc = 0;
    for (int b = 0; b < BIN_COUNT; b++) begin
      acc += bin_cnt[b];
      if (acc > rank) return b;
    end
    return BIN_COUNT - 1;
  endfunction

  // Push one sample through the histogram; returns 1 when a median is due.
  function automatic bit median_predict(input logic signed [SAMPLE_BITS-1:0] s,
                                        output logic signed [SAMPLE_BITS-1:0] med);
    int lo, hi, v, w, b, a, c;
    eff_bounds(lo, hi);
    v = s;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    b = v - lo;
    if (cfg_wlen == 0) w = 1;
    else if (int'(cfg_wlen) > MAX_WINDOW) w = MAX_WINDOW;
    else w = int'(cfg_wlen);
    if (ring_pos >= w) ring_pos = 0;
    // Full window: retire the oldest sample before adding the new one.
    if (fill_cnt >= w) begin
      if (bin_cnt[ring_bin[ring_pos]] > 0) bin_cnt[ring_bin[ring_pos]]--;
    end else begin
      fill_cnt++;
    end
    ring_bin[ring_pos] = b;
    bin_cnt[b]++;
    ring_pos++;
    if (ring_pos >= w) ring_pos = 0;
    med = '0;
    if (fill_cnt < w) return 1'b0;
    if (w % 2 == 1) begin
      a = lo + bin_at_rank(w / 2);
    end else begin
      a = lo + bin_at_rank(w / 2 - 1);
      c = lo + bin_at_rank(w / 2);
      a = (a + c) / 2;
    end
    med = a[SAMPLE_BITS-1:0];
    return 1'b1;
  endfunction

  // APB write: setup cycle, access cycle; the shadow copy follows at the access edge.
  task automatic reg_write(input logic [smh_pkg::REG_IDX_W-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      smh_pkg::REG_WINDOW_LENGTH: cfg_wlen = data[smh_pkg::WLEN_W-1:0];
      smh_pkg::REG_LOW_VALUE:     cfg_low = data[SAMPLE_BITS-1:0];
      smh_pkg::REG_HIGH_VALUE:    cfg_high = data[SAMPLE_BITS-1:0];
      default: ;
    endcase
    // Any real register write restarts the window empty.
    if (idx != REG_UNUSED) window_clear();
    writes_done++;
  endtask

  // Hold the sample side until every predicted median has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (median_q.size() != 0);
  endtask

  // Drain, then give the update of a non-producing sample and any clearing pass time to end.
  task automatic quiesce();
    drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  // One sample transfer, with an optional idle burst first. A typed median overrides the
  // predictor's value, but the predictor still advances so later rows stay in step.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic typed,
                             input logic signed [SAMPLE_BITS-1:0] typed_med);
    logic signed [SAMPLE_BITS-1:0] med;
    int                            gap;
    if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    if (median_predict(s, med)) median_q.push_back(typed ? typed_med : med);
    samples_sent++;
  endtask

  // Receiver pacing: random stall bursts while rx_odds is nonzero.
  initial begin : rx_pacing
    int gap;
    forever begin
      @(posedge clk);
      if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
        gap = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Result checker: every median transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      medians_seen++;
      if (median_q.size() == 0) begin
        report($sformatf("median %0d with nothing expected", median_out));
      end else if (median_out !== median_q[0]) begin
        report($sformatf("median got %0d, expected %0d", median_out, median_q[0]));
        void'(median_q.pop_front());
      end else begin
        void'(median_q.pop_front());
      end
    end
  end

  initial begin : stimulus
    int wl, lo, hi, elo, ehi, kind, pick, v, prev;
    window_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; the reset clearing pass is absorbed by waiting on in_ready.
    tx_odds = 4;
    rx_odds = 4;
    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        quiesce();
        reg_write(PLAN[r].idx, PLAN[r].val);
      end else begin
        send_sample(PLAN[r].val[SAMPLE_BITS-1:0], PLAN[r].typed, PLAN[r].med);
      end
    end

    // Random phases: each one picks a window and range, then streams samples.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: wl = 1;
        1: wl = 64;
        2: wl = 127;   // above MAX_WINDOW, acts as 64
        3: wl = 0;
        4: wl = 2;
        default: wl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 16);
      endcase
      kind = (p < 6) ? p : $urandom_range(0, 5);
      lo = int'($urandom_range(0, 65535)) - 32768;
      case (kind)
        0: hi = lo + int'($urandom_range(0, 255));
        1: hi = lo + 255;
        2: hi = lo + int'($urandom_range(0, 7));   // heavy duplicates
        3: hi = lo - int'($urandom_range(1, 255)); // reversed ends
        4: hi = int'($urandom_range(0, 65535)) - 32768;
        default: begin
          case ($urandom_range(0, 3))
            0: begin lo = -32768; hi = 32767; end
            1: begin lo = 32767; hi = -32768; end
            2: begin lo = 32512; hi = 32767; end
            default: begin lo = -32768; hi = -32768; end
          endcase
        end
      endcase
      if (hi > 32767) hi = 32767;
      if (hi < -32768) hi = -32768;

      // Tail phases run with no idling on either side.
      if (p >= PHASES - 2) begin
        tx_odds = 0;
        rx_odds = 0;
      end else begin
        tx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
        rx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      end

      if ($urandom_range(0, 3) == 0) begin
        quiesce();
        reg_write(REG_UNUSED, $urandom());
      end
      quiesce();
      reg_write(smh_pkg::REG_WINDOW_LENGTH, 32'(wl));
      quiesce();
      reg_write(smh_pkg::REG_LOW_VALUE, 32'(lo));
      quiesce();
      reg_write(smh_pkg::REG_HIGH_VALUE, 32'(hi));

      eff_bounds(elo, ehi);
      prev = elo;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Mostly in range (with a little spill over the ends), some raw 16-bit noise,
        // repeats for equal bins, and the two-s complement extremes.
        pick = $urandom_range(0, 99);
        if (pick < 65) v = elo - 2 + int'($urandom_range(0, ehi - elo + 4));
        else if (pick < 78) v = int'($urandom_range(0, 65535)) - 32768;
        else if (pick < 90) v = prev;
        else v = (pick % 2 == 1) ? 32767 : -32768;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        prev = v;
        if ((p == 5 && i == PHASE_ITEMS / 2) || $urandom_range(0, 149) == 0) drain();
        send_sample(16'(v), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d samples and %0d register writes; %0d medians compared.",
             samples_sent, writes_done, medians_seen);
    $display("Mismatches seen: %0d", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
